// ===== hw/rtl/mesd_pkg.sv =====
`default_nettype none

package mesd_pkg;

  localparam int unsigned MAX_FACES   = 64;
  localparam int unsigned VERTEX_BITS = 10;
  localparam int unsigned NV_W        = 11;
  localparam int unsigned IDX_W       = $clog2(MAX_FACES);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned KEY_W       = VERTEX_BITS + NV_W;
  localparam int unsigned FACE_W      = 42;
  localparam int unsigned IN_DATA_W   = 48;
  localparam int unsigned OUT_DATA_W  = 24;
  localparam int unsigned OUT_USER_W  = 2;

  localparam logic [NV_W-1:0] NV_RESET = NV_W'(1024);

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  typedef struct packed {
    logic [9:0] vertex_b;
    logic [9:0] vertex_a;
    logic [3:0] face_kind;
    logic [2:0] neighbor_face;
    logic [5:0] neighbor_cell;
    logic [2:0] local_face;
    logic [5:0] cell_index;
  } face_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
  } node_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mesd_cell.sv =====
`default_nettype none

module mesd_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           clr_i,
  input  logic           pop_i,
  input  mesd_pkg::node_t ins_i,
  input  mesd_pkg::node_t prev_i,
  input  logic           prev_le_i,
  input  mesd_pkg::node_t next_i,
  output mesd_pkg::node_t node_o,
  output logic           le_o
);
  import mesd_pkg::*;

  logic             valid_q;
  logic [KEY_W-1:0] key_q;
  logic [IDX_W-1:0] idx_q;
  logic             move;

  // keeps its entry when it is not above the new key, so equal keys stay in load order
  assign le_o   = valid_q && (key_q <= ins_i.key);
  assign move   = ins_i.valid && !le_o;
  assign node_o = '{valid: valid_q, key: key_q, idx: idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clr_i) begin
      valid_q <= 1'b0;
    end else if (pop_i) begin
      valid_q <= next_i.valid;
    end else if (move) begin
      valid_q <= prev_le_i ? 1'b1 : prev_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      key_q <= next_i.key;
      idx_q <= next_i.idx;
    end else if (move) begin
      if (prev_le_i) begin
        key_q <= ins_i.key;
        idx_q <= ins_i.idx;
      end else begin
        key_q <= prev_i.key;
        idx_q <= prev_i.idx;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mesd_chain.sv =====
`default_nettype none

module mesd_chain (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           clr_i,
  input  logic           pop_i,
  input  mesd_pkg::node_t ins_i,
  output mesd_pkg::node_t head_o
);
  import mesd_pkg::*;

  node_t node [MAX_FACES];
  logic  le   [MAX_FACES];

  for (genvar i = 0; i < MAX_FACES; i++) begin : g_cell
    node_t prev;
    node_t next;
    logic  prev_le;

    if (i == 0) begin : g_first
      assign prev    = '0;
      assign prev_le = 1'b1;
    end else begin : g_mid
      assign prev    = node[i-1];
      assign prev_le = le[i-1];
    end

    if (i == MAX_FACES - 1) begin : g_last
      assign next = '0;
    end else begin : g_inner
      assign next = node[i+1];
    end

    mesd_cell u_cell (
      .clk_i,
      .rst_ni,
      .clr_i,
      .pop_i,
      .ins_i,
      .prev_i    (prev),
      .prev_le_i (prev_le),
      .next_i    (next),
      .node_o    (node[i]),
      .le_o      (le[i])
    );
  end

  assign head_o = node[0];

endmodule

`default_nettype wire

// ===== hw/rtl/mesh_edge_sort_dedup_top.sv =====
// load: one face per cycle while idle, no output
// finish: key the n faces and insert them into the sorted cell chain, then
//   pop the chain, reading the memory read port for each emitted edge and each duplicate
//   face, until the chain is found empty; output stalls hold the run
// finish with no faces: one record; next request taken once the run is drained
// reset: face count and overflow flag cleared, num_vertices = 1024, face store contents undefined
`default_nettype none

module mesh_edge_sort_dedup_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mesd_pkg::NV_W-1:0]          cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // cell_index, local_face, neighbor_cell, neighbor_face, face_kind, vertex_a, vertex_b
  input  logic [mesd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // action
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // cell_minus, cell_plus, face_minus, face_plus, edge_kind
  output logic [mesd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // edge_valid, overflowed
  output logic [mesd_pkg::OUT_USER_W-1:0]    m_axis_tuser,
  output logic                               m_axis_tlast
);
  import mesd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMPTY,
    ST_FEED,
    ST_POP,
    ST_OUT
  } state_e;

  state_e           state_q;
  logic [NV_W-1:0]  nv_q;
  logic [CNT_W-1:0] count_q;
  logic             ovf_q;
  logic             ovf_run_q;
  logic [CNT_W-1:0] n_q;
  logic [CNT_W-1:0] rd_cnt_q;
  logic             rd_v_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             p_v_q;
  logic [KEY_W-1:0] prod_q;
  logic [VERTEX_BITS-1:0] hi_q;
  logic [IDX_W-1:0] p_idx_q;
  logic [KEY_W-1:0] max_q;
  logic [KEY_W-1:0] prev_key_q;
  logic             first_q;
  logic             last_q;
  logic             m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic [OUT_USER_W-1:0] m_user_q;
  logic             m_last_q;

  face_t            mem [MAX_FACES];
  face_t            mem_rd_q;
  logic [IDX_W-1:0] rd_addr;
  face_t            in_face;
  logic             in_acc;
  logic             do_load;
  logic             out_free;
  logic             out_load;
  logic             distinct;
  logic             feed_rd;
  logic [VERTEX_BITS-1:0] va;
  logic [VERTEX_BITS-1:0] vb;
  logic [VERTEX_BITS-1:0] lo;
  logic [VERTEX_BITS-1:0] hi;
  logic [KEY_W-1:0] new_key;
  node_t            ins;
  node_t            head;
  logic             chain_clr;
  logic             chain_pop;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_face       = face_t'(s_axis_tdata[FACE_W-1:0]);
  assign do_load       = in_acc && (s_axis_tuser == ACT_LOAD) && (count_q != CNT_W'(MAX_FACES));
  assign out_free      = !m_valid_q || m_axis_tready;
  assign out_load      = ((state_q == ST_EMPTY) || (state_q == ST_OUT)) && out_free;
  assign feed_rd       = (state_q == ST_FEED) && (rd_cnt_q != n_q);
  assign distinct      = first_q || (head.key != prev_key_q);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  // key pipeline: memory read, multiply, add into the chain
  assign va      = mem_rd_q.vertex_a[VERTEX_BITS-1:0];
  assign vb      = mem_rd_q.vertex_b[VERTEX_BITS-1:0];
  assign lo      = (va < vb) ? va : vb;
  assign hi      = (va < vb) ? vb : va;
  assign new_key = prod_q + KEY_W'(hi_q);
  assign ins     = '{valid: p_v_q, key: new_key, idx: p_idx_q};

  assign chain_clr = in_acc && (s_axis_tuser == ACT_FINISH);
  assign chain_pop = (state_q == ST_POP) && head.valid;
  assign rd_addr   = (state_q == ST_FEED) ? rd_cnt_q[IDX_W-1:0] : head.idx;

  mesd_chain u_chain (
    .clk_i,
    .rst_ni,
    .clr_i  (chain_clr),
    .pop_i  (chain_pop),
    .ins_i  (ins),
    .head_o (head)
  );

  // read data of the popped face is held while the output waits
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      mem[count_q[IDX_W-1:0]] <= in_face;
    end
    if (state_q != ST_OUT) begin
      mem_rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_cnt_q[IDX_W-1:0];
    prod_q   <= KEY_W'(lo * nv_q);
    hi_q     <= hi;
    p_idx_q  <= rd_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      nv_q       <= NV_RESET;
      count_q    <= '0;
      ovf_q      <= 1'b0;
      ovf_run_q  <= 1'b0;
      n_q        <= '0;
      rd_cnt_q   <= '0;
      rd_v_q     <= 1'b0;
      p_v_q      <= 1'b0;
      max_q      <= '0;
      prev_key_q <= '0;
      first_q    <= 1'b0;
      last_q     <= 1'b0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      m_user_q   <= '0;
      m_last_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        nv_q <= cfg_data_i;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      rd_v_q <= feed_rd;
      p_v_q  <= rd_v_q;
      if (p_v_q && (new_key > max_q)) begin
        max_q <= new_key;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser == ACT_LOAD) begin
              if (do_load) begin
                count_q <= count_q + CNT_W'(1);
              end else begin
                ovf_q <= 1'b1;
              end
            end else begin
              ovf_run_q <= ovf_q;
              ovf_q     <= 1'b0;
              n_q       <= count_q;
              count_q   <= '0;
              rd_cnt_q  <= '0;
              max_q     <= '0;
              first_q   <= 1'b1;
              state_q   <= (count_q == '0) ? ST_EMPTY : ST_FEED;
            end
          end
        end
        ST_EMPTY: begin
          if (out_free) begin
            m_data_q  <= '0;
            m_user_q  <= {ovf_run_q, 1'b0};
            m_last_q  <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        ST_FEED: begin
          if (feed_rd) begin
            rd_cnt_q <= rd_cnt_q + CNT_W'(1);
          end else if (!rd_v_q && !p_v_q) begin
            state_q <= ST_POP;
          end
        end
        ST_POP: begin
          if (!head.valid) begin
            state_q <= ST_IDLE;
          end else begin
            first_q    <= 1'b0;
            prev_key_q <= head.key;
            if (distinct) begin
              last_q  <= (head.key == max_q);
              state_q <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_data_q  <= {2'b00, mem_rd_q.face_kind, mem_rd_q.neighbor_face,
                          mem_rd_q.local_face, mem_rd_q.neighbor_cell, mem_rd_q.cell_index};
            m_user_q  <= {ovf_run_q, 1'b1};
            m_last_q  <= last_q;
            state_q   <= ST_POP;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
